@@ src/acoustic_wave_stencil_step_macros.svh @@
// Assertion macros for the acoustic wave stencil block.
`ifndef ACOUSTIC_WAVE_STENCIL_STEP_MACROS_SVH
`define ACOUSTIC_WAVE_STENCIL_STEP_MACROS_SVH
`ifndef SYNTHESIS
`define AWS_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define AWS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define AWS_ASSERT_IMPL(label, clk, rst, ante, cons)
`define AWS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ src/aws_pkg.sv @@
// Shared types and constants of the acoustic wave stencil block.
`default_nettype none
package aws_pkg;
  localparam int MAX_COLUMNS = 1024;
  localparam int MAX_ROWS = 4096;
  localparam int COL_W = $clog2(MAX_COLUMNS);
  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 48;
  localparam logic [CFG_IDX_W-1:0] REG_COURANT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_READ = 5'b00010,
    ST_COEF = 5'b00100,
    ST_MUL  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  typedef struct packed {
    logic capture;
    logic read;
    logic coef;
    logic mul;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic emit;
  } status_t;
endpackage
`default_nettype wire

@@ src/aws_ctrl.sv @@
// Controller state machine sequencing one request through the datapath.
`default_nettype none
module aws_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  wire logic out_ready,
  input  wire aws_pkg::status_t status,
  output aws_pkg::cmd_t cmd
);
  import aws_pkg::*;
  state_t state, state_next;
  logic out_full, out_full_next;

  always_comb begin
    state_next = state;
    out_full_next = out_full && !out_ready;
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        cmd.read = 1'b1;
        state_next = ST_COEF;
      end
      ST_COEF: begin
        cmd.coef = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!status.emit) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end else if (!out_full_next) begin
          cmd.finish = 1'b1;
          out_full_next = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_full <= 1'b0;
    end else begin
      state <= state_next;
      out_full <= out_full_next;
    end
  end

  assign out_valid = out_full;
endmodule
`default_nettype wire

@@ src/aws_dp.sv @@
// Datapath: line buffers, position counters, coefficient and stencil arithmetic.
`default_nettype none
module aws_dp (
  input  wire logic clk,
  input  wire logic rst,
  input  wire aws_pkg::cmd_t cmd,
  output aws_pkg::status_t status,
  input  wire logic cfg_write,
  input  wire logic [aws_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [aws_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic signed [31:0] current_sample,
  input  wire logic signed [31:0] previous_sample,
  input  wire logic [15:0] velocity,
  output logic signed [31:0] next_sample,
  output logic [11:0] out_row,
  output logic [9:0] out_column,
  output logic frame_done
);
  import aws_pkg::*;
  logic [47:0] courant;
  logic [12:0] row_cfg;
  logic [10:0] col_cfg;
  logic [ROW_W:0] rows;
  logic [COL_W:0] cols;
  logic [ROW_W-1:0] row_pos;
  logic [COL_W-1:0] col_pos;
  logic [31:0] cur_mem [0:2*MAX_COLUMNS-1];
  logic [31:0] prv_mem [0:MAX_COLUMNS-1];
  logic [15:0] vel_mem [0:MAX_COLUMNS-1];
  logic signed [31:0] cur_in, prv_in;
  logic [15:0] vel_in;
  logic signed [31:0] ctr, up, lft, rgt, prv;
  logic [15:0] vel;
  logic emit, last;
  logic [COL_W-1:0] cm1, cp1;
  logic [31:0] v2;
  logic [24:0] coef;
  logic [56:0] hi_p;
  logic [48:0] lo_p;
  logic [57:0] csum;
  logic signed [35:0] lap;
  logic signed [61:0] prod;
  logic signed [37:0] term;
  logic signed [39:0] res;
  logic quiet;

  assign rows = (row_cfg < 13'd3) ? (ROW_W+1)'(3) :
                (row_cfg > 13'(MAX_ROWS)) ? (ROW_W+1)'(MAX_ROWS) : (ROW_W+1)'(row_cfg);
  assign cols = (col_cfg < 11'd3) ? (COL_W+1)'(3) :
                (col_cfg > 11'(MAX_COLUMNS)) ? (COL_W+1)'(MAX_COLUMNS) : (COL_W+1)'(col_cfg);
  assign cm1 = col_pos - COL_W'(1);
  assign cp1 = col_pos + COL_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      courant <= '0;
      row_cfg <= 13'd3;
      col_cfg <= 11'd3;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_COURANT: courant <= cfg_data;
        REG_ROWS: row_cfg <= cfg_data[12:0];
        REG_COLS: col_cfg <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_in <= current_sample;
      prv_in <= previous_sample;
      vel_in <= velocity;
    end
  end

  // Line buffer reads are split over the capture and read steps.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ctr <= cur_mem[{~row_pos[0], col_pos}];
      up <= cur_mem[{row_pos[0], col_pos}];
      vel <= vel_mem[col_pos];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      lft <= cur_mem[{~row_pos[0], cm1}];
      rgt <= cur_mem[{~row_pos[0], cp1}];
      prv <= prv_mem[col_pos];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      emit <= (ROW_W+1)'(row_pos) >= (ROW_W+1)'(2) && (ROW_W+1)'(row_pos) < rows &&
              col_pos != '0 && (COL_W+1)'(col_pos) + (COL_W+1)'(1) < cols;
      last <= (ROW_W+1)'(row_pos) == rows - (ROW_W+1)'(1) &&
              (COL_W+1)'(col_pos) == cols - (COL_W+1)'(2);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read) v2 <= 32'(vel) * 32'(vel);
  end

  always_ff @(posedge clk) begin
    if (cmd.coef) begin
      hi_p <= 57'(courant[47:24]) * 57'(v2);
      lo_p <= 49'((56'(courant[23:0]) * 56'(v2)) >> 24);
      lap <= 36'(up) + 36'(cur_in) + 36'(lft) + 36'(rgt) - (36'(ctr) <<< 2);
    end
  end

  assign csum = 58'(hi_p) + 58'(lo_p);
  assign coef = (csum > 58'(1 << 24)) ? 25'(1 << 24) : csum[24:0];
  assign term = 38'(prod >>> 24);
  assign res = 40'(term) + (40'(ctr) <<< 1) - 40'(prv);
  assign quiet = prv == 0 && up == 0 && cur_in == 0 && lft == 0 && rgt == 0;

  always_ff @(posedge clk) begin
    if (cmd.mul) prod <= $signed({1'b0, coef}) * lap;
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && emit) begin
      if (quiet) next_sample <= ctr;
      else if (res > 40'sh007FFFFFFF) next_sample <= 32'sh7FFFFFFF;
      else if (res < -40'sh0080000000) next_sample <= 32'sh80000000;
      else next_sample <= res[31:0];
      out_row <= 12'(row_pos - ROW_W'(1));
      out_column <= 10'(col_pos);
      frame_done <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      cur_mem[{row_pos[0], col_pos}] <= cur_in;
      prv_mem[col_pos] <= prv_in;
      vel_mem[col_pos] <= vel_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_pos <= '0;
      col_pos <= '0;
    end else if (cmd.finish) begin
      if ((COL_W+1)'(col_pos) + (COL_W+1)'(1) >= cols) begin
        col_pos <= '0;
        if ((ROW_W+1)'(row_pos) + (ROW_W+1)'(1) >= rows) row_pos <= '0;
        else row_pos <= row_pos + ROW_W'(1);
      end else begin
        col_pos <= cp1;
      end
    end
  end

  assign status.emit = emit;
endmodule
`default_nettype wire

@@ src/acoustic_wave_stencil_step.sv @@
// Top level: sequential request, one at a time; an emitted result goes to an output register.
// After acceptance a request passes the read, coefficient, multiply and write-back steps;
// the write-back step stalls while an emitted result finds the output register still full.
// Results are held in one output register so the next request is accepted while one waits.
// Synchronous reset resets the controller, positions and config; line buffers need no clear.
`default_nettype none
`include "acoustic_wave_stencil_step_macros.svh"
module acoustic_wave_stencil_step (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_write,
  input  wire logic [aws_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [aws_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic signed [31:0] current_sample,
  input  wire logic signed [31:0] previous_sample,
  input  wire logic [15:0] velocity,
  output logic out_valid,
  input  wire logic out_ready,
  output logic signed [31:0] next_sample,
  output logic [11:0] out_row,
  output logic [9:0] out_column,
  output logic frame_done
);
  import aws_pkg::*;
  cmd_t cmd;
  status_t status;

  aws_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .status(status), .cmd(cmd)
  );

  aws_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status), .cfg_write(cfg_write),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .current_sample(current_sample),
    .previous_sample(previous_sample), .velocity(velocity), .next_sample(next_sample),
    .out_row(out_row), .out_column(out_column), .frame_done(frame_done)
  );

  `AWS_ASSERT_NEXT(a_capture_reads, clk, rst, cmd.capture, cmd.read)
  `AWS_ASSERT_IMPL(a_one_cmd, clk, rst, 1'b1, $onehot0(cmd))
  `AWS_ASSERT_NEXT(a_emit_valid, clk, rst, cmd.finish && status.emit, out_valid)
endmodule
`default_nettype wire
